// ===== src/glpf_pkg.sv =====
// ----------------------------------------------------------------------------
// glpf_pkg
// Shared constants and types of the grid local peak finder.
// ----------------------------------------------------------------------------
package glpf_pkg;

    // Default sizes of the block
    localparam int MAX_ROWS_DEF   = 32;
    localparam int MAX_COLS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 16;

    // Configuration port geometry: two 32-bit registers at byte 0 and 4
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int SIZE_W     = 6;
    localparam int COORD_W    = 5;

    // Register index, taken from paddr[2]
    localparam logic REG_GRID_ROWS = 1'b0;
    localparam logic REG_GRID_COLS = 1'b1;

    localparam logic [SIZE_W-1:0] GRID_SIZE_RST = 6'd32;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_FLUSH
    } t_glpf_state;

    // Effective frame size and restart strobe from the register block
    typedef struct packed {
        logic [SIZE_W-1:0] last_row;
        logic [SIZE_W-1:0] last_col;
        logic              restart;
    } t_glpf_size;

endpackage

// ===== src/glpf_if.sv =====
// ----------------------------------------------------------------------------
// glpf_pix_if / glpf_peak_if
// Valid/ready channels carrying pixel words in and peak words out.
// ----------------------------------------------------------------------------
interface glpf_pix_if
    import glpf_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

interface glpf_peak_if
    import glpf_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] peak_row;
    logic [COORD_W-1:0] peak_col;
    logic               run_last;

    modport source (output valid, output peak_row, output peak_col, output run_last,
                    input ready);
    modport sink   (input valid, input peak_row, input peak_col, input run_last,
                    output ready);
endinterface

// ===== src/glpf_cfg.sv =====
// ----------------------------------------------------------------------------
// glpf_cfg
// APB register block: grid size registers, clamping to the effective frame
// size and a restart strobe on every write.
// ----------------------------------------------------------------------------
module glpf_cfg
    import glpf_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_glpf_size            o_size
);

    logic [SIZE_W-1:0] r_grid_rows;
    logic [SIZE_W-1:0] r_grid_cols;
    logic              w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= GRID_SIZE_RST;
            r_grid_cols <= GRID_SIZE_RST;
        end else if (w_wr) begin
            case (paddr[2])
                REG_GRID_ROWS: r_grid_rows <= pwdata[SIZE_W-1:0];
                REG_GRID_COLS: r_grid_cols <= pwdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (paddr[2])
            REG_GRID_ROWS: prdata = CFG_DATA_W'(r_grid_rows);
            REG_GRID_COLS: prdata = CFG_DATA_W'(r_grid_cols);
            default:       prdata = '0;
        endcase
    end

    // effective size: zero acts as one, oversize clamps to the maximum
    always_comb begin
        if (r_grid_rows == '0) begin
            o_size.last_row = '0;
        end else if (32'(r_grid_rows) > MAX_ROWS) begin
            o_size.last_row = SIZE_W'(MAX_ROWS - 1);
        end else begin
            o_size.last_row = r_grid_rows - 1'b1;
        end
        if (r_grid_cols == '0) begin
            o_size.last_col = '0;
        end else if (32'(r_grid_cols) > MAX_COLS) begin
            o_size.last_col = SIZE_W'(MAX_COLS - 1);
        end else begin
            o_size.last_col = r_grid_cols - 1'b1;
        end
        o_size.restart = w_wr;
    end

endmodule

// ===== src/grid_local_peak_finder.sv =====
// ----------------------------------------------------------------------------
// grid_local_peak_finder
// 4-neighbour local maxima of a signed raster grid, reported in raster order.
// ----------------------------------------------------------------------------
// Each pixel passes three steps: accept (read of its column word), a read of
// the next column's word, then evaluation and write-back; the single read
// port of the column store sets this sequence. A peak of row r is sent with the
// pixel below it. The frame's final pixel is followed by a walk over the
// last-row peak flags, one column a cycle unless a peak waits on a stalled output. A
// stalled output holds the sequencer. Any register write restarts the frame.
// ----------------------------------------------------------------------------
module grid_local_peak_finder
    import glpf_pkg::*;
#(
    parameter int MAX_ROWS   = MAX_ROWS_DEF,
    parameter int MAX_COLS   = MAX_COLS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    glpf_pix_if.sink              i_pix,
    glpf_peak_if.source           o_peak,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int RW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int WORD = 2 * VALUE_BITS;

    t_glpf_size  w_size;
    t_glpf_state r_state, n_state;

    // column store: per column the two most recent rows {latest, previous}
    logic [WORD-1:0] mem [MAX_COLS];
    logic [WORD-1:0] r_rdata;
    logic [WORD-1:0] r_col_word;

    logic [RW-1:0]                r_row;
    logic [CW-1:0]                r_col;
    logic [CW-1:0]                r_k;
    logic signed [VALUE_BITS-1:0] r_pix, r_pix1, r_pix2, r_prev_ctr;
    logic [MAX_COLS-1:0]          r_flags, n_flags, w_flags_rest;

    logic               r_out_valid;
    logic [COORD_W-1:0] r_out_row, r_out_col;
    logic               r_out_last;

    logic               w_out_free;
    logic               w_rd_en;
    logic [CW-1:0]      w_raddr;
    logic [CW:0]        w_col_nxt;
    logic               w_eval_go;
    logic               w_emit;
    logic [COORD_W-1:0] w_emit_row, w_emit_col;
    logic               w_emit_last;
    logic               w_flush_take;

    logic signed [VALUE_BITS-1:0] w_ctr, w_up, w_right;
    logic w_has_above, w_has_up2, w_has_left, w_has_left2;
    logic w_last_col, w_last_row, w_final;
    logic w_pk_above, w_pk_prev, w_pk_here;

    glpf_cfg #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_size  (w_size)
    );

    // position decode
    assign w_has_above = (r_row != '0);
    assign w_has_up2   = (32'(r_row) >= 2);
    assign w_has_left  = (r_col != '0);
    assign w_has_left2 = (32'(r_col) >= 2);
    assign w_last_col  = (32'(r_col) == 32'(w_size.last_col));
    assign w_last_row  = (32'(r_row) == 32'(w_size.last_row));
    assign w_final     = w_last_row & w_last_col;

    // window around the cell above the current pixel
    assign w_ctr   = r_col_word[WORD-1:VALUE_BITS];
    assign w_up    = r_col_word[VALUE_BITS-1:0];
    assign w_right = r_rdata[WORD-1:VALUE_BITS];

    // cell above: all four neighbours have arrived
    assign w_pk_above = w_has_above
                      && !(w_has_up2 && (w_ctr < w_up))
                      && !(w_ctr < r_pix)
                      && !(w_has_left && (w_ctr < r_prev_ctr))
                      && !(!w_last_col && (w_ctr < w_right));

    // last row: left neighbour of the current pixel is now complete
    assign w_pk_prev = w_last_row && w_has_left
                     && !(w_has_above && (r_pix1 < r_prev_ctr))
                     && !(w_has_left2 && (r_pix1 < r_pix2))
                     && !(r_pix1 < r_pix);

    // last row, last column: the pixel itself
    assign w_pk_here = w_final
                     && !(w_has_above && (r_pix < w_ctr))
                     && !(w_has_left && (r_pix < r_pix1));

    // last-row flags after this pixel
    always_comb begin
        for (int k = 0; k < MAX_COLS; k++) begin
            n_flags[k] = r_flags[k]
                       | (w_pk_prev && (32'(r_col) == k + 1))
                       | (w_pk_here && (32'(r_col) == k));
        end
    end

    // flags still pending once the current flush column is sent
    always_comb begin
        w_flags_rest = r_flags;
        w_flags_rest[r_k] = 1'b0;
    end

    // next column read address, wrapped inside the store
    assign w_col_nxt = {1'b0, r_col} + 1'b1;

    assign w_out_free = !r_out_valid || o_peak.ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_pix.valid) n_state = ST_READ;
            ST_READ:  n_state = ST_EVAL;
            ST_EVAL:  if (w_out_free) n_state = w_final ? ST_FLUSH : ST_IDLE;
            ST_FLUSH: if (r_flags == '0) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        i_pix.ready  = 1'b0;
        w_rd_en      = 1'b0;
        w_raddr      = r_col;
        w_eval_go    = 1'b0;
        w_flush_take = 1'b0;
        w_emit       = 1'b0;
        w_emit_row   = COORD_W'(r_row - 1'b1);
        w_emit_col   = COORD_W'(r_col);
        w_emit_last  = !(w_final && (n_flags != '0));
        case (r_state)
            ST_IDLE: begin
                i_pix.ready = 1'b1;
                w_rd_en     = 1'b1;
            end
            ST_READ: begin
                w_rd_en = 1'b1;
                w_raddr = (32'(w_col_nxt) >= MAX_COLS) ? '0 : w_col_nxt[CW-1:0];
            end
            ST_EVAL: begin
                w_eval_go = w_out_free;
                w_emit    = w_out_free && w_pk_above;
            end
            ST_FLUSH: begin
                w_flush_take = (r_flags != '0) && (!r_flags[r_k] || w_out_free);
                w_emit       = (r_flags != '0) && r_flags[r_k] && w_out_free;
                w_emit_row   = COORD_W'(w_size.last_row);
                w_emit_col   = COORD_W'(r_k);
                w_emit_last  = (w_flags_rest == '0);
            end
            default: ;
        endcase
    end

    // column store read port
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rdata <= mem[w_raddr];
        end
    end

    // column store write-back: shift the column's two rows
    always_ff @(posedge i_clk) begin
        if (w_eval_go) begin
            mem[r_col] <= {r_pix, w_ctr};
        end
    end

    // pixel and window registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_pix.valid) begin
            r_pix <= i_pix.pixel_value;
        end
        if (r_state == ST_READ) begin
            r_col_word <= r_rdata;
        end
        if (w_eval_go) begin
            r_pix2     <= r_pix1;
            r_pix1     <= r_pix;
            r_prev_ctr <= w_ctr;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_k     <= '0;
            r_flags <= '0;
        end else begin
            r_state <= n_state;
            // register write restarts the frame
            if (w_size.restart) begin
                r_row   <= '0;
                r_col   <= '0;
                r_flags <= '0;
            end else if (w_eval_go) begin
                r_flags <= n_flags;
                r_k     <= '0;
                if (w_last_col) begin
                    r_col <= '0;
                    r_row <= w_last_row ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end else if (w_flush_take) begin
                r_flags[r_k] <= 1'b0;
                r_k          <= r_k + 1'b1;
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_peak.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_row  <= w_emit_row;
            r_out_col  <= w_emit_col;
            r_out_last <= w_emit_last;
        end
    end

    assign o_peak.valid    = r_out_valid;
    assign o_peak.peak_row = r_out_row;
    assign o_peak.peak_col = r_out_col;
    assign o_peak.run_last = r_out_last;

endmodule
